// ===== src/cfdx_pkg.sv =====
// cfdx_pkg: shared types and constants for the command frame deframer
// holds frame marker bytes, field widths, result status codes and the parser phase type
// no dependencies

package cfdx_pkg;

  // frame marker bytes
  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'hAA;
  localparam logic [7:0] TYPE_CMD   = 8'h05;
  localparam logic [7:0] TYPE_NULL  = 8'h00;
  localparam logic [7:0] END_MARK   = 8'hF0;

  // frame layout
  localparam int BodyLen   = 5;
  localparam int IdxW      = $clog2(BodyLen);
  localparam int CountW    = 4;
  localparam logic [CountW-1:0] IdxFirstBody = 4'd3;
  localparam logic [CountW-1:0] IdxLastBody  = 4'd7;
  localparam logic [CountW-1:0] IdxCheck     = 4'd8;
  localparam logic [CountW-1:0] IdxEnd       = 4'd9;

  // result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // parser phase
  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_SYNC2 = 2'd1,
    PH_TYPE  = 2'd2,
    PH_BODY  = 2'd3
  } phase_t;

endpackage

// ===== src/command_frame_deframer_xor.sv =====
// command_frame_deframer_xor: finds 10-byte command frames in a byte stream
// and gives one result per type 0x05 frame with xor check and end byte test
// depends on cfdx_pkg
//
//  channel  | dir | signals                    | content
//  ---------+-----+----------------------------+--------------------------------
//  s_axis   | in  | tvalid tready tdata[7:0]   | rx_byte
//  m_axis   | out | tvalid tready tdata[39:0]  | cmd_byte, arg_byte_a..d
//           |     | tuser[0]                   | frame_status
//
// one byte is taken per cycle while s_axis_tready is high; the parser state and the result register update
// on the same edge, so a result appears in the cycle after the tenth byte is taken.
// the output register holds a result until it is taken; s_axis_tready is low
// only while a result waits and m_axis_tready is low.
// rst is synchronous and active high and returns the parser to header hunt.

module command_frame_deframer_xor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] cmd_byte, [15:8] arg_byte_a,
                                      // [23:16] arg_byte_b, [31:24] arg_byte_c,
                                      // [39:32] arg_byte_d
  output logic [0:0]  m_axis_tuser    // [0] frame_status
);

  // parser state
  cfdx_pkg::phase_t                 phase, phase_next;
  logic [cfdx_pkg::CountW-1:0]      byte_count, byte_count_next;
  logic [7:0]                       running_xor, running_xor_next;
  logic                             type_is_command, type_is_command_next;
  logic [7:0]                       body_bytes [cfdx_pkg::BodyLen];
  logic [7:0]                       check_byte;

  // result register
  logic                             out_valid;
  logic                             out_status;
  logic [39:0]                      out_data;

  logic                             in_xfer;
  logic                             body_wr;
  logic [cfdx_pkg::IdxW-1:0]        body_idx;
  logic                             check_wr;
  logic                             emit;
  logic                             emit_status;
  logic [cfdx_pkg::CountW-1:0]      body_off;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_status;

  // next state of the parser
  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    running_xor_next     = running_xor;
    type_is_command_next = type_is_command;
    if (in_xfer) begin
      case (phase)
        cfdx_pkg::PH_HUNT: begin
          if (s_axis_tdata == cfdx_pkg::HDR_FIRST) phase_next = cfdx_pkg::PH_SYNC2;
        end
        cfdx_pkg::PH_SYNC2: begin
          phase_next = (s_axis_tdata == cfdx_pkg::HDR_SECOND) ? cfdx_pkg::PH_TYPE
                                                              : cfdx_pkg::PH_HUNT;
        end
        cfdx_pkg::PH_TYPE: begin
          if (s_axis_tdata == cfdx_pkg::TYPE_NULL || s_axis_tdata == cfdx_pkg::TYPE_CMD) begin
            type_is_command_next = (s_axis_tdata == cfdx_pkg::TYPE_CMD);
            running_xor_next     = s_axis_tdata;
            byte_count_next      = cfdx_pkg::IdxFirstBody;
            phase_next           = cfdx_pkg::PH_BODY;
          end else begin
            phase_next = cfdx_pkg::PH_HUNT;
          end
        end
        cfdx_pkg::PH_BODY: begin
          if (byte_count <= cfdx_pkg::IdxLastBody) begin
            running_xor_next = running_xor ^ s_axis_tdata;
            byte_count_next  = byte_count + 1'b1;
          end else if (byte_count == cfdx_pkg::IdxCheck) begin
            byte_count_next = cfdx_pkg::IdxEnd;
          end else begin
            byte_count_next = '0;
            phase_next      = cfdx_pkg::PH_HUNT;
          end
        end
        default: phase_next = cfdx_pkg::PH_HUNT;
      endcase
    end
  end

  // storage strobes and result decision
  always_comb begin
    body_off    = byte_count - cfdx_pkg::IdxFirstBody;
    body_idx    = body_off[cfdx_pkg::IdxW-1:0];
    body_wr     = in_xfer && phase == cfdx_pkg::PH_BODY
                  && byte_count >= cfdx_pkg::IdxFirstBody
                  && byte_count <= cfdx_pkg::IdxLastBody;
    check_wr    = in_xfer && phase == cfdx_pkg::PH_BODY && byte_count == cfdx_pkg::IdxCheck;
    emit        = in_xfer && phase == cfdx_pkg::PH_BODY && byte_count > cfdx_pkg::IdxCheck
                  && type_is_command;
    emit_status = (running_xor == check_byte && s_axis_tdata == cfdx_pkg::END_MARK)
                  ? cfdx_pkg::STATUS_OK : cfdx_pkg::STATUS_ERR;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= cfdx_pkg::PH_HUNT;
      byte_count      <= '0;
      running_xor     <= '0;
      type_is_command <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      running_xor     <= running_xor_next;
      type_is_command <= type_is_command_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame payload and result payload
  always_ff @(posedge clk) begin
    if (body_wr) begin
      body_bytes[body_idx] <= s_axis_tdata;
    end
    if (check_wr) begin
      check_byte <= s_axis_tdata;
    end
    if (emit) begin
      out_status <= emit_status;
      out_data   <= {body_bytes[4], body_bytes[3], body_bytes[2],
                     body_bytes[1], body_bytes[0]};
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    phase == cfdx_pkg::PH_BODY |-> byte_count >= cfdx_pkg::IdxFirstBody
                                   && byte_count <= cfdx_pkg::IdxEnd)
    else $error("byte count out of frame range");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    emit |-> type_is_command && byte_count == cfdx_pkg::IdxEnd)
    else $error("result from a non-command frame or wrong byte");

  a_type_entry: assert property (@(posedge clk) disable iff (rst)
    (phase == cfdx_pkg::PH_TYPE && $past(phase) != cfdx_pkg::PH_TYPE)
      |-> $past(phase) == cfdx_pkg::PH_SYNC2)
    else $error("type phase entered without second header byte");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result is stalled");

  a_body_leaves_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && phase == cfdx_pkg::PH_BODY && byte_count == cfdx_pkg::IdxEnd)
      |=> phase == cfdx_pkg::PH_HUNT)
    else $error("parser did not return to hunt after end byte");

endmodule

// ===== sim/command_frame_deframer_xor_tb.sv =====
// command_frame_deframer_xor_tb: byte-stream testbench for the command frame deframer
// feeds framed and broken byte traffic, predicts each frame result and checks m_axis
// depends on cfdx_pkg and command_frame_deframer_xor
`timescale 1ns / 1ps

module command_frame_deframer_xor_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  // one frame result as the block reports it
  typedef struct packed {
    logic       status;
    logic [7:0] cmd;
    logic [7:0] arg_a;
    logic [7:0] arg_b;
    logic [7:0] arg_c;
    logic [7:0] arg_d;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  command_frame_deframer_xor u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // stimulus and expectation stores
  logic [7:0]    rx_byte_queue [$];
  frame_result_t pending_frames [$];
  int            bytes_queued = 0;
  int            bytes_taken  = 0;
  logic          byte_taken_now = 1'b0;

  // idle percentages and long hold request
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  // predictor state
  cfdx_pkg::phase_t            parse_phase = cfdx_pkg::PH_HUNT;
  logic [cfdx_pkg::CountW-1:0] frame_idx   = '0;
  logic [7:0]                  xor_acc     = 8'h00;
  logic                        is_command  = 1'b0;
  logic [7:0]                  body_store [cfdx_pkg::BodyLen];
  logic [7:0]                  check_store = 8'h00;

  // run statistics
  int frames_ok      = 0;
  int frames_bad     = 0;
  int frames_null    = 0;
  int headers_broken = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  // advance the frame parser by one byte and queue any result it gives
  task automatic parse_rx_byte(input logic [7:0] b);
    frame_result_t res;
    int            slot;
    case (parse_phase)
      cfdx_pkg::PH_HUNT: begin
        if (b == cfdx_pkg::HDR_FIRST) parse_phase = cfdx_pkg::PH_SYNC2;
      end
      cfdx_pkg::PH_SYNC2: begin
        if (b == cfdx_pkg::HDR_SECOND) begin
          parse_phase = cfdx_pkg::PH_TYPE;
        end else begin
          parse_phase = cfdx_pkg::PH_HUNT;
          headers_broken++;
        end
      end
      cfdx_pkg::PH_TYPE: begin
        if (b == cfdx_pkg::TYPE_NULL || b == cfdx_pkg::TYPE_CMD) begin
          is_command  = (b == cfdx_pkg::TYPE_CMD);
          xor_acc     = b;
          frame_idx   = cfdx_pkg::IdxFirstBody;
          parse_phase = cfdx_pkg::PH_BODY;
        end else begin
          parse_phase = cfdx_pkg::PH_HUNT;
          headers_broken++;
        end
      end
      default: begin
        if (frame_idx <= cfdx_pkg::IdxLastBody) begin
          if (frame_idx >= cfdx_pkg::IdxFirstBody) begin
            slot = (int'(frame_idx) - int'(cfdx_pkg::IdxFirstBody)) % cfdx_pkg::BodyLen;
            body_store[slot] = b;
          end
          xor_acc   = xor_acc ^ b;
          frame_idx = frame_idx + 1'b1;
        end else if (frame_idx == cfdx_pkg::IdxCheck) begin
          check_store = b;
          frame_idx   = cfdx_pkg::IdxEnd;
        end else begin
          if (is_command) begin
            res.status = (xor_acc == check_store && b == cfdx_pkg::END_MARK)
                         ? cfdx_pkg::STATUS_OK : cfdx_pkg::STATUS_ERR;
            res.cmd    = body_store[0];
            res.arg_a  = body_store[1];
            res.arg_b  = body_store[2];
            res.arg_c  = body_store[3];
            res.arg_d  = body_store[4];
            pending_frames.push_back(res);
            if (res.status == cfdx_pkg::STATUS_OK) frames_ok++;
            else frames_bad++;
          end else begin
            frames_null++;
          end
          parse_phase = cfdx_pkg::PH_HUNT;
          frame_idx   = '0;
        end
      end
    endcase
  endtask

  // compare one delivered result against the oldest expectation
  task automatic check_frame(input frame_result_t got);
    frame_result_t want;
    results_seen++;
    if (pending_frames.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] unexpected result: status %0d cmd %02h args %02h %02h %02h %02h",
                 $realtime, got.status, got.cmd, got.arg_a, got.arg_b, got.arg_c, got.arg_d);
    end else begin
      want = pending_frames.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] result mismatch: expected status %0d cmd %02h args %02h %02h %02h %02h",
                   $realtime, want.status, want.cmd, want.arg_a, want.arg_b, want.arg_c,
                   want.arg_d);
          $display("[%0t]   got status %0d cmd %02h args %02h %02h %02h %02h",
                   $realtime, got.status, got.cmd, got.arg_a, got.arg_b, got.arg_c,
                   got.arg_d);
        end
      end
    end
  endtask

  // monitor: both transfers are sampled at the rising edge
  always @(posedge clk) begin
    frame_result_t got;
    byte_taken_now = 1'b0;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser[0];
        got.cmd    = m_axis_tdata[7:0];
        got.arg_a  = m_axis_tdata[15:8];
        got.arg_b  = m_axis_tdata[23:16];
        got.arg_c  = m_axis_tdata[31:24];
        got.arg_d  = m_axis_tdata[39:32];
        check_frame(got);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_rx_byte(s_axis_tdata);
        bytes_taken++;
        byte_taken_now = 1'b1;
      end
    end
  end

  // driver: offer the next byte once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || byte_taken_now) begin
      if (rx_byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_byte_queue.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random backpressure plus an occasional long hold
  always @(negedge clk) begin
    if (hold_request != hold_served) begin
      hold_served   <= hold_request;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_frames.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    rx_byte_queue.push_back(b);
    bytes_queued++;
  endtask

  // body byte with a bias toward the extremes and the marker values
  function automatic logic [7:0] body_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 8'h00;
    if (pick < 20) return 8'hFF;
    if (pick < 25) return cfdx_pkg::HDR_FIRST;
    if (pick < 30) return cfdx_pkg::HDR_SECOND;
    if (pick < 33) return cfdx_pkg::END_MARK;
    return 8'($urandom_range(255));
  endfunction

  // full ten-byte frame
  task automatic queue_frame(input logic [7:0] kind,
                             input logic [8*cfdx_pkg::BodyLen-1:0] body,
                             input logic [7:0] chk, input logic [7:0] tail);
    queue_byte(cfdx_pkg::HDR_FIRST);
    queue_byte(cfdx_pkg::HDR_SECOND);
    queue_byte(kind);
    for (int i = 0; i < cfdx_pkg::BodyLen; i++) queue_byte(body[8*i +: 8]);
    queue_byte(chk);
    queue_byte(tail);
  endtask

  function automatic logic [7:0] body_xor(input logic [7:0] kind,
                                          input logic [8*cfdx_pkg::BodyLen-1:0] body);
    logic [7:0] acc;
    acc = kind;
    for (int i = 0; i < cfdx_pkg::BodyLen; i++) acc = acc ^ body[8*i +: 8];
    return acc;
  endfunction

  // mostly well-formed frames with random content, some broken headers and noise
  task automatic queue_traffic(input int frame_bytes);
    int                             done;
    int                             pick;
    int                             noise_len;
    logic [7:0]                     kind;
    logic [7:0]                     chk;
    logic [7:0]                     tail;
    logic [7:0]                     junk;
    logic [8*cfdx_pkg::BodyLen-1:0] body;
    done = 0;
    while (done < frame_bytes) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        kind = ($urandom_range(99) < 80) ? cfdx_pkg::TYPE_CMD : cfdx_pkg::TYPE_NULL;
        for (int i = 0; i < cfdx_pkg::BodyLen; i++) body[8*i +: 8] = body_value();
        chk  = ($urandom_range(99) < 75) ? body_xor(kind, body) : 8'($urandom_range(255));
        tail = ($urandom_range(99) < 80) ? cfdx_pkg::END_MARK : 8'($urandom_range(255));
        queue_frame(kind, body, chk, tail);
        done += 10;
      end else if (pick < 80) begin
        // wrong second byte
        junk = 8'($urandom_range(255));
        while (junk == cfdx_pkg::HDR_SECOND) junk = 8'($urandom_range(255));
        queue_byte(cfdx_pkg::HDR_FIRST);
        queue_byte(junk);
        done += 2;
      end else if (pick < 88) begin
        // wrong type byte
        junk = 8'($urandom_range(255));
        while (junk == cfdx_pkg::TYPE_CMD || junk == cfdx_pkg::TYPE_NULL)
          junk = 8'($urandom_range(255));
        queue_byte(cfdx_pkg::HDR_FIRST);
        queue_byte(cfdx_pkg::HDR_SECOND);
        queue_byte(junk);
        done += 3;
      end else begin
        // line noise between frames
        noise_len = $urandom_range(3, 1);
        repeat (noise_len) queue_byte(8'($urandom_range(255)));
        done += noise_len;
      end
    end
  endtask

  // sender pause: wait until every byte is taken and every result has arrived
  task automatic wait_drained();
    @(negedge clk);
    while (bytes_taken != bytes_queued || pending_frames.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: marker values and extremes in the body, a null frame, broken headers
    send_idle_pct = 31;
    recv_idle_pct = 48;
    queue_frame(cfdx_pkg::TYPE_CMD, {8'hAA, 8'h55, 8'h00, 8'hFF, 8'h55},
                body_xor(cfdx_pkg::TYPE_CMD, {8'hAA, 8'h55, 8'h00, 8'hFF, 8'h55}),
                cfdx_pkg::END_MARK);
    queue_frame(cfdx_pkg::TYPE_NULL, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 8'h12, 8'h34);
    // a repeated 0x55 breaks the header and is not taken as a new start
    queue_byte(cfdx_pkg::HDR_FIRST);
    queue_byte(cfdx_pkg::HDR_FIRST);
    queue_byte(cfdx_pkg::HDR_SECOND);
    queue_byte(cfdx_pkg::TYPE_CMD);
    // 0x55 as the type byte is rejected, the following 0xAA is ignored
    queue_byte(cfdx_pkg::HDR_FIRST);
    queue_byte(cfdx_pkg::HDR_SECOND);
    queue_byte(cfdx_pkg::HDR_FIRST);
    queue_byte(cfdx_pkg::HDR_SECOND);
    wait_drained();

    // random traffic, sender idling less than receiver
    queue_traffic(280);
    wait_drained();

    // random traffic, roles swapped
    send_idle_pct = 48;
    recv_idle_pct = 31;
    queue_traffic(280);
    wait_drained();

    // no idling; receiver holds off for a long stretch so the input stalls
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = hold_request + 1;
    queue_traffic(270);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("bytes taken %0d, results checked %0d (%0d accepted, %0d error)",
             bytes_taken, results_seen, frames_ok, frames_bad);
    $display("silent null frames %0d, abandoned headers %0d, mismatches %0d",
             frames_null, headers_broken, mismatches);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
